// ----- design/scrc_pkg.sv -----
// ----------------------------------------------------------------------------
// scrc_pkg
// shared constants and types for the size class run cache
// ----------------------------------------------------------------------------
package scrc_pkg;

  localparam int CLASS_COUNT = 16;
  localparam int CAP         = 16;
  localparam int PTR_BITS    = 48;

  // fixed field widths
  localparam int OUT_W   = 48;
  localparam int PAGES_W = 16;
  localparam int ALIGN_W = 6;
  localparam int SC_W    = 16;
  localparam int LCAP_W  = 5;

  // derived widths
  localparam int STORE_W = (PTR_BITS < OUT_W) ? PTR_BITS : OUT_W;
  localparam int CLS_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int FILL_W  = $clog2(CAP + 1);
  localparam int DEPTH   = CLASS_COUNT * CAP;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = (FILL_W > LCAP_W) ? FILL_W : LCAP_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_CAP  = 2'd1;
  localparam logic [LCAP_W-1:0]    LCAP_RESET     = 5'd16;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // class decode constants
  localparam logic [ALIGN_W-1:0] ALIGN_BASE  = 6'd12;
  localparam logic [ALIGN_W-1:0] ALIGN_8K    = 6'd13;
  localparam logic [ALIGN_W-1:0] ALIGN_TOP   = 6'd15;
  localparam logic [PAGES_W-1:0] PAGES_ONE   = 16'd1;
  localparam logic [PAGES_W-1:0] PAGES_TWO   = 16'd2;
  localparam logic [PAGES_W-1:0] PAGES_LARGE = 16'd16;
  localparam logic [SC_W-1:0]    SC_SMALL    = 16'd2048;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic fetch;
  } scrc_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } scrc_sts_t;

endpackage

// ----- design/scrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// scrc_ctrl
// sequencer for the run cache: accept, decode and update, memory fetch
// ----------------------------------------------------------------------------
module scrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scrc_pkg::scrc_cmd_t cmd_o,
  input  scrc_pkg::scrc_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_FETCH  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;
  logic   go;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = res_valid_q;

  // the result register may be reused once its word leaves at this edge
  assign go = !res_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    cmd_o.load_req = 1'b0;
    cmd_o.exec     = 1'b0;
    cmd_o.fetch    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (go) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.pop_hit ? ST_FETCH : ST_IDLE;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (!out_stall_i) begin
      res_valid_d = 1'b0;
    end
    if ((cmd_o.exec && !sts_i.pop_hit) || cmd_o.fetch) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

// ----- design/scrc_datapath.sv -----
// ----------------------------------------------------------------------------
// scrc_datapath
// class decode, per-class fill counters, slot memory and result register
// ----------------------------------------------------------------------------
module scrc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  scrc_pkg::scrc_cmd_t                  cmd_i,
  output scrc_pkg::scrc_sts_t                  sts_o,
  input  logic                                 cfg_we_i,
  input  logic [scrc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [scrc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 req_type_i,
  input  logic [scrc_pkg::OUT_W-1:0]           run_ptr_i,
  input  logic                                 meta_ok_i,
  input  logic [scrc_pkg::PAGES_W-1:0]         run_pages_i,
  input  logic [scrc_pkg::ALIGN_W-1:0]         align_shift_i,
  input  logic [scrc_pkg::SC_W-1:0]            size_class_i,
  output logic                                 ok_o,
  output logic [scrc_pkg::OUT_W-1:0]           out_ptr_o
);

  // configuration
  logic                          split_q;
  logic [scrc_pkg::LCAP_W-1:0]   lcap_q;

  // latched request
  logic                          req_q;
  logic [scrc_pkg::STORE_W-1:0]  ptr_q;
  logic                          mok_q;
  logic [scrc_pkg::PAGES_W-1:0]  pages_q;
  logic [scrc_pkg::ALIGN_W-1:0]  align_q;
  logic [scrc_pkg::SC_W-1:0]     sc_q;

  logic [scrc_pkg::FILL_W-1:0]   fill_q [scrc_pkg::CLASS_COUNT];
  logic [scrc_pkg::STORE_W-1:0]  mem [scrc_pkg::DEPTH];
  logic [scrc_pkg::STORE_W-1:0]  rdata_q;

  logic                          ok_q;
  logic [scrc_pkg::OUT_W-1:0]    ptr_out_q;

  logic [1:0]                    ab, pb;
  logic [3:0]                    cls;
  logic                          cls_ok;
  logic [scrc_pkg::CLS_W-1:0]    cls_sel;
  logic [scrc_pkg::FILL_W-1:0]   fill_sel;
  logic                          large_run;
  logic                          full;
  logic                          push_ok;
  logic                          pop_hit;
  logic [scrc_pkg::ADDR_W-1:0]   wr_addr, rd_addr;

  always_comb begin
    if (align_q >= scrc_pkg::ALIGN_TOP) begin
      ab = 2'd3;
    end else if (align_q > scrc_pkg::ALIGN_BASE) begin
      ab = 2'(align_q - scrc_pkg::ALIGN_BASE);
    end else begin
      ab = 2'd0;
    end
    if (pages_q <= scrc_pkg::PAGES_ONE) begin
      pb = 2'd0;
    end else if (pages_q <= scrc_pkg::PAGES_TWO) begin
      pb = 2'd1;
    end else if (pages_q <= scrc_pkg::PAGES_LARGE) begin
      pb = 2'd2;
    end else begin
      pb = 2'd3;
    end
    // in split mode, small one-page 8k runs fold into class zero
    if (split_q && pages_q <= scrc_pkg::PAGES_ONE && align_q == scrc_pkg::ALIGN_8K &&
        sc_q <= scrc_pkg::SC_SMALL) begin
      cls = 4'd0;
    end else begin
      cls = {pb, ab};
    end
  end

  assign cls_ok   = ({1'b0, cls} < 5'(scrc_pkg::CLASS_COUNT));
  assign cls_sel  = scrc_pkg::CLS_W'(cls);
  assign fill_sel = cls_ok ? fill_q[cls_sel] : '0;

  assign large_run = (align_q == scrc_pkg::ALIGN_8K) && (pages_q == scrc_pkg::PAGES_LARGE);
  assign full = (fill_sel >= scrc_pkg::FILL_W'(scrc_pkg::CAP)) ||
                (large_run && (scrc_pkg::CMP_W'(fill_sel) >= scrc_pkg::CMP_W'(lcap_q)));

  assign push_ok = (req_q == scrc_pkg::REQ_PUSH) && mok_q && (pages_q != '0) && cls_ok && !full;
  assign pop_hit = (req_q == scrc_pkg::REQ_POP) && cls_ok && (fill_sel != '0);
  assign sts_o.pop_hit = pop_hit;

  assign wr_addr = scrc_pkg::ADDR_W'(int'(cls_sel) * scrc_pkg::CAP + int'(fill_sel));
  assign rd_addr = scrc_pkg::ADDR_W'(int'(cls_sel) * scrc_pkg::CAP + int'(fill_sel) - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= 1'b0;
      lcap_q  <= scrc_pkg::LCAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scrc_pkg::CFG_SPLIT_MODE: split_q <= cfg_data_i[0];
        scrc_pkg::CFG_LARGE_CAP:  lcap_q  <= cfg_data_i[scrc_pkg::LCAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < scrc_pkg::CLASS_COUNT; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (push_ok) begin
        fill_q[cls_sel] <= fill_sel + 1'b1;
      end else if (pop_hit) begin
        fill_q[cls_sel] <= fill_sel - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q   <= req_type_i;
      ptr_q   <= run_ptr_i[scrc_pkg::STORE_W-1:0];
      mok_q   <= meta_ok_i;
      pages_q <= run_pages_i;
      align_q <= align_shift_i;
      sc_q    <= size_class_i;
    end
  end

  // slot memory, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      mem[wr_addr] <= ptr_q;
    end
    if (cmd_i.exec && pop_hit) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      ok_q      <= 1'b1;
      ptr_out_q <= scrc_pkg::OUT_W'(rdata_q);
    end else if (cmd_i.exec && !pop_hit) begin
      ok_q      <= push_ok;
      ptr_out_q <= '0;
    end
  end

  assign ok_o      = ok_q;
  assign out_ptr_o = ptr_out_q;

endmodule

// ----- design/size_class_run_cache_unit.sv -----
// ----------------------------------------------------------------------------
// size_class_run_cache_unit
// per-size-class lifo cache of freed run pointers
// ----------------------------------------------------------------------------
// One request is in work at a time. A push, a refused push or a pop miss
// goes from acceptance through decode and fill counter update to the
// result register; a pop hit adds the registered read of the slot
// memory before its fetch. The next request is accepted in the cycle
// after the previous one has updated the class fill counters, or after
// its slot fetch for a pop hit, so the unit does not take a new request
// before the previous one is through. A request waits in decode while the
// previous result is still stalled in the output register. Fill counters
// clear at reset, so no clearing pass is needed; slot memory contents are
// undefined until pushed. Configuration writes are always ready and must
// only be issued while the unit is idle.
module size_class_run_cache_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [scrc_pkg::OUT_W-1:0]      run_ptr_i,
  input  logic                            meta_ok_i,
  input  logic [scrc_pkg::PAGES_W-1:0]    run_pages_i,
  input  logic [scrc_pkg::ALIGN_W-1:0]    align_shift_i,
  input  logic [scrc_pkg::SC_W-1:0]       size_class_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            ok_o,
  output logic [scrc_pkg::OUT_W-1:0]      out_ptr_o
);

  scrc_pkg::scrc_cmd_t cmd;
  scrc_pkg::scrc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  scrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  scrc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .run_ptr_i     (run_ptr_i),
    .meta_ok_i     (meta_ok_i),
    .run_pages_i   (run_pages_i),
    .align_shift_i (align_shift_i),
    .size_class_i  (size_class_i),
    .ok_o          (ok_o),
    .out_ptr_o     (out_ptr_o)
  );

endmodule

// ----- design/scrc_checker.sv -----
// ----------------------------------------------------------------------------
// scrc_checker
// port-level checks for the size class run cache
// ----------------------------------------------------------------------------
module scrc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       ok_o,
  input logic [scrc_pkg::OUT_W-1:0] out_ptr_o
);

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // one request in work: the cycle after an accept the input is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted while one is in work");

  // a result only appears after work on a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without a request in work");

  // refused pushes and pop misses carry a zero pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> out_ptr_o == '0)
    else $error("nonzero pointer on a failed request");

endmodule

bind size_class_run_cache_unit scrc_checker u_scrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ok_o        (ok_o),
  .out_ptr_o   (out_ptr_o)
);
